FILE: sv/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, constants and microcode for the glyph charmap block
// Holds the control-word layout, the sequencer program, the status group
// and the row conversion helper.
// ----------------------------------------------------------------------------
package gdc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_GLYPHS_DEF = 256;
  localparam int MAX_ROWS_DEF   = 16;

  // Port and register widths fixed by the field layout
  localparam int PIX_W      = 64;
  localparam int ROW_W      = 8;
  localparam int GH_W       = 5;
  localparam int ATTR_W     = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CHAR_W     = 16;
  localparam int USER_W     = 2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_HEIGHT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ATTRIBUTE    = 1'd1;

  localparam logic [GH_W-1:0]   GH_RESET   = 5'd16;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd248;

  // Result flag positions in tuser
  localparam int USER_NEW  = 0;
  localparam int USER_FULL = 1;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_INC_R,
    OP_INC_G,
    OP_WR,
    OP_EMIT_FOUND,
    OP_EMIT_NEW,
    OP_EMIT_FULL
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOT_GO,
    C_G_END,
    C_MISMATCH,
    C_NOT_LAST,
    C_FULL,
    C_NOT_ROW_END
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram step addresses
  localparam upc_t U_IDLE   = 4'd0;
  localparam upc_t U_ISSUE  = 4'd1;
  localparam upc_t U_CMP    = 4'd2;
  localparam upc_t U_ROW_OK = 4'd3;
  localparam upc_t U_FOUND  = 4'd4;
  localparam upc_t U_NEXT_G = 4'd5;
  localparam upc_t U_STORE  = 4'd6;
  localparam upc_t U_WRITE  = 4'd7;
  localparam upc_t U_NEW    = 4'd8;
  localparam upc_t U_FULL   = 4'd9;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  wait_out;   // hold this step while the output word is occupied
    upc_t  target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic idle;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic go;          // last row of a cell accepted
    logic g_end;       // glyph counter reached the stored count
    logic mismatch;    // stored row differs from the cell row
    logic last_row;    // row counter at the last row of the cell
    logic full;        // no free table entry
    logic row_end;     // row counter at the last buffer row
    logic out_busy;    // output word still waiting
  } status_t;

  // Control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    case (a)
      U_IDLE:   w = '{op: OP_IDLE,       cond: C_NOT_GO,      wait_out: 1'b0, target: U_IDLE};
      U_ISSUE:  w = '{op: OP_NOP,        cond: C_G_END,       wait_out: 1'b0, target: U_STORE};
      U_CMP:    w = '{op: OP_NOP,        cond: C_MISMATCH,    wait_out: 1'b0, target: U_NEXT_G};
      U_ROW_OK: w = '{op: OP_INC_R,      cond: C_NOT_LAST,    wait_out: 1'b0, target: U_ISSUE};
      U_FOUND:  w = '{op: OP_EMIT_FOUND, cond: C_ALWAYS,      wait_out: 1'b1, target: U_IDLE};
      U_NEXT_G: w = '{op: OP_INC_G,      cond: C_ALWAYS,      wait_out: 1'b0, target: U_ISSUE};
      U_STORE:  w = '{op: OP_NOP,        cond: C_FULL,        wait_out: 1'b0, target: U_FULL};
      U_WRITE:  w = '{op: OP_WR,         cond: C_NOT_ROW_END, wait_out: 1'b0, target: U_WRITE};
      U_NEW:    w = '{op: OP_EMIT_NEW,   cond: C_ALWAYS,      wait_out: 1'b1, target: U_IDLE};
      U_FULL:   w = '{op: OP_EMIT_FULL,  cond: C_ALWAYS,      wait_out: 1'b1, target: U_IDLE};
      default:  w = '{op: OP_NOP,        cond: C_ALWAYS,      wait_out: 1'b0, target: U_IDLE};
    endcase
    return w;
  endfunction

  // Zero pixel byte -> set bit, pixel 0 in the MSB
  function automatic logic [ROW_W-1:0] row_from_pixels(logic [PIX_W-1:0] px);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = (px[8*i +: 8] == 8'h00);
    end
    return r;
  endfunction

endpackage

FILE: sv/gdc_ram.sv
// ----------------------------------------------------------------------------
// gdc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gdc_useq.sv
// ----------------------------------------------------------------------------
// gdc_useq: microcode sequencer
// Step counter over the control store, one conditional jump per word,
// and a hold on result steps while the output word is occupied.
// ----------------------------------------------------------------------------
module gdc_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  gdc_pkg::status_t  status,
  output gdc_pkg::ctrl_t    ctrl
);

  gdc_pkg::upc_t   upc_r, upc_nxt;
  gdc_pkg::uword_t uw;
  logic            take;
  logic            stall;

  assign uw = gdc_pkg::ucode(upc_r);

  // Condition select
  always_comb begin
    case (uw.cond)
      gdc_pkg::C_ALWAYS:      take = 1'b1;
      gdc_pkg::C_NOT_GO:      take = !status.go;
      gdc_pkg::C_G_END:       take = status.g_end;
      gdc_pkg::C_MISMATCH:    take = status.mismatch;
      gdc_pkg::C_NOT_LAST:    take = !status.last_row;
      gdc_pkg::C_FULL:        take = status.full;
      gdc_pkg::C_NOT_ROW_END: take = !status.row_end;
      default:                take = 1'b0;
    endcase
  end

  assign stall = uw.wait_out && status.out_busy;

  // Next step
  always_comb begin
    if (stall) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= gdc_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.op   = stall ? gdc_pkg::OP_NOP : uw.op;
  assign ctrl.idle = (upc_r == gdc_pkg::U_IDLE);

endmodule

FILE: sv/gdc_dpath.sv
// ----------------------------------------------------------------------------
// gdc_dpath: glyph charmap datapath
// Row intake and cell buffer, glyph and row counters, compare against the
// glyph store, table fill and the output word register.
// ----------------------------------------------------------------------------
module gdc_dpath #(
  parameter int MAX_GLYPHS = gdc_pkg::MAX_GLYPHS_DEF,
  parameter int MAX_ROWS   = gdc_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gdc_pkg::ctrl_t                    ctrl,
  output gdc_pkg::status_t                  status,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     h_eff,
  input  logic [gdc_pkg::ATTR_W-1:0]        attr,
  // input rows
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gdc_pkg::PIX_W-1:0]         in_tdata,
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gdc_pkg::CHAR_W-1:0]        out_tdata,
  output logic [gdc_pkg::USER_W-1:0]        out_tuser,
  // glyph store
  output logic                              ram_we,
  output logic [$clog2(MAX_GLYPHS)+$clog2(MAX_ROWS)-1:0] ram_waddr,
  output logic [gdc_pkg::ROW_W-1:0]         ram_wdata,
  output logic [$clog2(MAX_GLYPHS)+$clog2(MAX_ROWS)-1:0] ram_raddr,
  input  logic [gdc_pkg::ROW_W-1:0]         ram_rdata
);

  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int GW = $clog2(MAX_GLYPHS + 1);
  localparam int GI = $clog2(MAX_GLYPHS);

  logic [gdc_pkg::ROW_W-1:0] buf_r [MAX_ROWS];
  logic [HW-1:0]             rpos_r, rpos_nxt;
  logic [GW-1:0]             g_r, g_nxt;
  logic [RW-1:0]             r_r, r_nxt;
  logic [GW-1:0]             cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [gdc_pkg::CHAR_W-1:0] out_data_r, out_data_nxt;
  logic [gdc_pkg::USER_W-1:0] out_user_r, out_user_nxt;

  logic                      in_fire;
  logic                      cell_done;
  logic [HW:0]               rpos_inc;
  logic [gdc_pkg::ROW_W-1:0] cell_row;
  logic                      row_in_cell;

  // Row intake
  assign in_tready = ctrl.idle;
  assign in_fire   = in_tvalid && in_tready;
  assign rpos_inc  = {1'b0, rpos_r} + 1'b1;
  assign cell_done = (rpos_inc >= {1'b0, h_eff});

  always_comb begin
    rpos_nxt = rpos_r;
    if (in_fire) begin
      rpos_nxt = cell_done ? '0 : rpos_inc[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (int'(rpos_r) < MAX_ROWS)) begin
      buf_r[rpos_r[RW-1:0]] <= gdc_pkg::row_from_pixels(in_tdata);
    end
  end

  // Row of the cell under the row counter; rows past the height are stored as zero
  assign cell_row    = buf_r[r_r];
  assign row_in_cell = (HW'(r_r) < h_eff);

  // Glyph store access
  assign ram_raddr = {g_r[GI-1:0], r_r};
  assign ram_waddr = {cnt_r[GI-1:0], r_r};
  assign ram_wdata = row_in_cell ? cell_row : '0;
  assign ram_we    = (ctrl.op == gdc_pkg::OP_WR);

  // Counters and output word
  always_comb begin
    g_nxt         = g_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (ctrl.op)
      gdc_pkg::OP_IDLE: begin
        g_nxt = '0;
        r_nxt = '0;
      end
      gdc_pkg::OP_INC_R: begin
        r_nxt = r_r + 1'b1;
      end
      gdc_pkg::OP_INC_G: begin
        g_nxt = g_r + 1'b1;
        r_nxt = '0;
      end
      gdc_pkg::OP_WR: begin
        r_nxt = status.row_end ? '0 : r_r + 1'b1;
      end
      gdc_pkg::OP_EMIT_FOUND: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {attr, ~8'(g_r)};
        out_user_nxt  = '0;
      end
      gdc_pkg::OP_EMIT_NEW: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {attr, ~8'(cnt_r)};
        out_user_nxt  = '0;
        out_user_nxt[gdc_pkg::USER_NEW] = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
      end
      gdc_pkg::OP_EMIT_FULL: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {attr, 8'h00};
        out_user_nxt  = '0;
        out_user_nxt[gdc_pkg::USER_FULL] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpos_r      <= '0;
      g_r         <= '0;
      r_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rpos_r      <= rpos_nxt;
      g_r         <= g_nxt;
      r_r         <= r_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Status back to the sequencer
  assign status.go       = in_fire && cell_done;
  assign status.g_end    = (g_r == cnt_r);
  assign status.mismatch = (ram_rdata != cell_row);
  assign status.last_row = ((HW'(r_r) + 1'b1) == h_eff);
  assign status.full     = (int'(cnt_r) == MAX_GLYPHS);
  assign status.row_end  = (r_r == RW'(MAX_ROWS - 1));
  assign status.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: sv/glyph_dedup_charmap.sv
// ----------------------------------------------------------------------------
// glyph_dedup_charmap: bitmap rows to deduplicated text-mode character words
// Top level: configuration registers, sequencer, datapath and glyph store.
// ----------------------------------------------------------------------------
// Each word on the input is one 8-pixel row of a character cell. A row that
// does not finish a cell is only buffered. The row that finishes a cell
// starts a compare of the cell against the stored glyphs, in storage order,
// one row at a time through the single read port of the glyph store; each
// compared row passes the issue, compare and row-advance steps (or the
// next-glyph step on a mismatch), with early exit on the first differing row.
// A glyph with no match then passes the end-of-table check, the full check,
// one store write per buffer row and the result load. One character word
// (attribute byte high, inverted glyph index low) leaves per cell; new_glyph
// and table_full ride in tuser. Further rows are accepted while a finished
// word waits on the output.
module glyph_dedup_charmap #(
  parameter int MAX_GLYPHS = gdc_pkg::MAX_GLYPHS_DEF,
  parameter int MAX_ROWS   = gdc_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [gdc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gdc_pkg::CFG_W-1:0]         cfg_wdata,
  // input rows
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gdc_pkg::PIX_W-1:0]         in_tdata,   // [63:0] pixel_bytes
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gdc_pkg::CHAR_W-1:0]        out_tdata,  // [15:0] char_word
  output logic [gdc_pkg::USER_W-1:0]        out_tuser   // [0] new_glyph, [1] table_full
);

  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int AW = $clog2(MAX_GLYPHS) + $clog2(MAX_ROWS);

  logic [gdc_pkg::GH_W-1:0]   gh_r;
  logic [gdc_pkg::ATTR_W-1:0] attr_r;
  logic [HW-1:0]              h_eff;

  gdc_pkg::ctrl_t             ctrl;
  gdc_pkg::status_t           status;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [gdc_pkg::ROW_W-1:0]  ram_wdata;
  logic [gdc_pkg::ROW_W-1:0]  ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gh_r   <= gdc_pkg::GH_RESET;
      attr_r <= gdc_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        gdc_pkg::CFG_GLYPH_HEIGHT: gh_r   <= cfg_wdata[gdc_pkg::GH_W-1:0];
        gdc_pkg::CFG_ATTRIBUTE:    attr_r <= cfg_wdata[gdc_pkg::ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Height clamped to 1..MAX_ROWS
  always_comb begin
    if (gh_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(gh_r) > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(gh_r);
    end
  end

  gdc_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  gdc_dpath #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .status     (status),
    .h_eff      (h_eff),
    .attr       (attr_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Glyph store: one row byte per entry, rows of a glyph side by side
  gdc_ram #(
    .WIDTH (gdc_pkg::ROW_W),
    .DEPTH (MAX_GLYPHS << $clog2(MAX_ROWS))
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A result is only loaded into a free output word
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == gdc_pkg::OP_EMIT_FOUND || ctrl.op == gdc_pkg::OP_EMIT_NEW ||
     ctrl.op == gdc_pkg::OP_EMIT_FULL) |-> !status.out_busy)
    else $error("result loaded while output word occupied");

  // No glyph is stored into a full table
  a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == gdc_pkg::OP_EMIT_NEW || ctrl.op == gdc_pkg::OP_WR) |-> !status.full)
    else $error("glyph stored with table full");

  // A loaded result shows on the output next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == gdc_pkg::OP_EMIT_FOUND || ctrl.op == gdc_pkg::OP_EMIT_NEW ||
     ctrl.op == gdc_pkg::OP_EMIT_FULL) |=> out_tvalid)
    else $error("result lost after load");

  // Rows are only taken while the sequencer waits
  a_intake_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (ctrl.op == gdc_pkg::OP_IDLE))
    else $error("row accepted outside idle step");

endmodule
